// ----- design/gslm_pkg.sv -----
package gslm_pkg;

    localparam int DEF_MAX_WIDTH   = 64;
    localparam int DEF_MAX_HEIGHT  = 64;
    localparam int DEF_SAMPLE_BITS = 16;

    localparam int CFG_W   = 7;
    localparam int CFG_IDX_W = 2;
    localparam int POS_W   = 7;
    localparam int ORD_W   = 11;

    localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 7'd64;
    localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 7'd64;
    localparam logic [CFG_W-1:0] RST_TARGET_ROW   = 7'd0;
    localparam logic [CFG_W-1:0] RST_TARGET_COL   = 7'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_HEIGHT = 2'd0,
        REG_FRAME_WIDTH  = 2'd1,
        REG_TARGET_ROW   = 2'd2,
        REG_TARGET_COL   = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic probe;
        logic summary;
        logic last;
    } probe_tag_t;

endpackage

// ----- design/gslm_cell.sv -----
module gslm_cell #(
    parameter int SAMPLE_BITS = gslm_pkg::DEF_SAMPLE_BITS
) (
    input  logic                        clk,
    input  logic                        shift,
    input  logic                        clear,
    input  logic [2:0][SAMPLE_BITS-1:0] col_in,
    output logic [2:0][SAMPLE_BITS-1:0] col_out
);

    logic [2:0][SAMPLE_BITS-1:0] col_reg;
    logic [2:0][SAMPLE_BITS-1:0] col_next;

    always_comb
    begin
        col_next = col_reg;
        if (shift)
        begin
            col_next = clear ? '0 : col_in;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg <= col_next;
    end

    assign col_out = col_reg;

endmodule

// ----- design/gslm_line_buf.sv -----
module gslm_line_buf #(
    parameter int MAX_WIDTH   = gslm_pkg::DEF_MAX_WIDTH,
    parameter int SAMPLE_BITS = gslm_pkg::DEF_SAMPLE_BITS,
    parameter int ADDR_W      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic                   clk,
    input  logic                   wr_en,
    input  logic [ADDR_W-1:0]      wr_addr,
    input  logic [SAMPLE_BITS-1:0] wr_above,
    input  logic [SAMPLE_BITS-1:0] wr_mid,
    input  logic                   rd_en,
    input  logic [ADDR_W-1:0]      rd_addr,
    output logic [SAMPLE_BITS-1:0] rd_above,
    output logic [SAMPLE_BITS-1:0] rd_mid
);

    logic [SAMPLE_BITS-1:0] above_mem [MAX_WIDTH];
    logic [SAMPLE_BITS-1:0] mid_mem   [MAX_WIDTH];
    logic [SAMPLE_BITS-1:0] rd_above_reg;
    logic [SAMPLE_BITS-1:0] rd_mid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            above_mem[wr_addr] <= wr_above;
            mid_mem[wr_addr]   <= wr_mid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_above_reg <= above_mem[rd_addr];
            rd_mid_reg   <= mid_mem[rd_addr];
        end
    end

    assign rd_above = rd_above_reg;
    assign rd_mid   = rd_mid_reg;

endmodule

// ----- design/gslm_probe.sv -----
module gslm_probe #(
    parameter int SAMPLE_BITS = gslm_pkg::DEF_SAMPLE_BITS,
    parameter int ROW_W       = 7,
    parameter int COL_W       = 7
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              step,
    input  gslm_pkg::probe_tag_t              tag,
    input  logic [ROW_W-1:0]                  row1,
    input  logic [COL_W-1:0]                  col1,
    input  logic [2:0][SAMPLE_BITS-1:0]       win_left,
    input  logic [2:0][SAMPLE_BITS-1:0]       win_centre,
    input  logic [2:0][SAMPLE_BITS-1:0]       win_right,
    input  logic [gslm_pkg::CFG_W-1:0]        target_row,
    input  logic [gslm_pkg::CFG_W-1:0]        target_col,
    output logic                              out_valid,
    output logic [gslm_pkg::POS_W-1:0]        peak_row,
    output logic [gslm_pkg::POS_W-1:0]        peak_col,
    output logic [gslm_pkg::ORD_W-1:0]        peak_ordinal,
    output logic                              is_summary,
    output logic                              target_hit,
    output logic                              last_of_run
);

    localparam int PosW = gslm_pkg::POS_W;
    localparam int OrdW = gslm_pkg::ORD_W;

    logic                 valid_reg;
    logic                 valid_next;
    logic [PosW-1:0]      row_reg;
    logic [PosW-1:0]      row_next;
    logic [PosW-1:0]      col_reg;
    logic [PosW-1:0]      col_next;
    logic [OrdW-1:0]      ord_reg;
    logic [OrdW-1:0]      ord_next;
    logic                 summary_reg;
    logic                 summary_next;
    logic                 hit_out_reg;
    logic                 hit_out_next;
    logic                 last_reg;
    logic                 last_next;
    logic [OrdW-1:0]      peak_cnt_reg;
    logic [OrdW-1:0]      peak_cnt_next;
    logic                 hit_flag_reg;
    logic                 hit_flag_next;
    logic                 is_peak;
    logic                 on_target;
    logic [OrdW-1:0]      cnt_inc;
    logic signed [SAMPLE_BITS-1:0] centre;

    always_comb
    begin
        centre  = $signed(win_centre[1]);
        is_peak = (centre > $signed(win_left[0]))   && (centre > $signed(win_left[1])) &&
                  (centre > $signed(win_left[2]))   && (centre > $signed(win_centre[0])) &&
                  (centre > $signed(win_centre[2])) && (centre > $signed(win_right[0])) &&
                  (centre > $signed(win_right[1]))  && (centre > $signed(win_right[2]));
    end

    assign on_target = (32'(row1) == 32'(target_row)) && (32'(col1) == 32'(target_col));
    assign cnt_inc   = (peak_cnt_reg == '1) ? peak_cnt_reg : OrdW'(peak_cnt_reg + 1'b1);

    always_comb
    begin
        valid_next    = valid_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        ord_next      = ord_reg;
        summary_next  = summary_reg;
        hit_out_next  = hit_out_reg;
        last_next     = last_reg;
        peak_cnt_next = peak_cnt_reg;
        hit_flag_next = hit_flag_reg;
        if (step)
        begin
            valid_next = 1'b0;
            if (tag.summary)
            begin
                valid_next    = 1'b1;
                row_next      = '0;
                col_next      = '0;
                ord_next      = peak_cnt_reg;
                summary_next  = 1'b1;
                hit_out_next  = hit_flag_reg;
                last_next     = 1'b1;
                peak_cnt_next = '0;
                hit_flag_next = 1'b0;
            end
            else if (tag.probe && is_peak)
            begin
                valid_next    = 1'b1;
                row_next      = PosW'(row1);
                col_next      = PosW'(col1);
                ord_next      = cnt_inc;
                summary_next  = 1'b0;
                hit_out_next  = 1'b0;
                last_next     = tag.last;
                peak_cnt_next = cnt_inc;
                hit_flag_next = hit_flag_reg | on_target;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            peak_cnt_reg <= '0;
            hit_flag_reg <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            peak_cnt_reg <= peak_cnt_next;
            hit_flag_reg <= hit_flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg     <= row_next;
        col_reg     <= col_next;
        ord_reg     <= ord_next;
        summary_reg <= summary_next;
        hit_out_reg <= hit_out_next;
        last_reg    <= last_next;
    end

    assign out_valid    = valid_reg;
    assign peak_row     = row_reg;
    assign peak_col     = col_reg;
    assign peak_ordinal = ord_reg;
    assign is_summary   = summary_reg;
    assign target_hit   = hit_out_reg;
    assign last_of_run  = last_reg;

endmodule

// ----- design/grid_strict_local_maxima.sv -----
// Strict 3x3 local-maximum detector for a raster-order frame of signed samples, with
// out-of-frame neighbors taken as zero. Within a row the block takes one sample per
// cycle; the last sample of a row blocks the input while the window drains the row
// end, and the last sample of the frame blocks it while the single read port of the
// line buffers replays the final row through the window before the summary
// transaction. A result waiting on out_ready stalls the whole chain. Judgments lag
// their samples by one row and one column.
module grid_strict_local_maxima #(
    parameter int MAX_WIDTH   = gslm_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = gslm_pkg::DEF_MAX_HEIGHT,
    parameter int SAMPLE_BITS = gslm_pkg::DEF_SAMPLE_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [SAMPLE_BITS-1:0]      sample,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [gslm_pkg::POS_W-1:0]         peak_row,
    output logic [gslm_pkg::POS_W-1:0]         peak_col,
    output logic [gslm_pkg::ORD_W-1:0]         peak_ordinal,
    output logic                               is_summary,
    output logic                               target_hit,
    output logic                               last_of_run,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [gslm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gslm_pkg::CFG_W-1:0]         cfg_data
);

    localparam int RowW  = $clog2(MAX_HEIGHT + 1);
    localparam int ColW  = $clog2(MAX_WIDTH + 1);
    localparam int AddrW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CfgW  = gslm_pkg::CFG_W;

    typedef enum logic [3:0] {
        ST_RUN   = 4'b0001,
        ST_EOR   = 4'b0010,
        ST_FLUSH = 4'b0100,
        ST_SUM   = 4'b1000
    } seq_state_t;

    logic [CfgW-1:0]        frame_height_reg;
    logic [CfgW-1:0]        frame_width_reg;
    logic [CfgW-1:0]        target_row_reg;
    logic [CfgW-1:0]        target_col_reg;

    logic [RowW-1:0]        row_cnt_reg;
    logic [RowW-1:0]        row_cnt_next;
    logic [ColW-1:0]        col_cnt_reg;
    logic [ColW-1:0]        col_cnt_next;

    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    logic [SAMPLE_BITS-1:0] s1_sample_reg;
    logic [RowW-1:0]        s1_r_reg;
    logic [ColW-1:0]        s1_c_reg;
    logic                   s1_eor_reg;
    logic                   s1_final_reg;

    seq_state_t             state_reg;
    seq_state_t             state_next;
    logic [ColW-1:0]        fl_j_reg;
    logic [ColW-1:0]        fl_j_next;

    gslm_pkg::probe_tag_t   tag_reg;
    gslm_pkg::probe_tag_t   tag_next;
    logic [RowW-1:0]        row1_reg;
    logic [RowW-1:0]        row1_next;
    logic [ColW-1:0]        col1_reg;
    logic [ColW-1:0]        col1_next;

    logic                   advance;
    logic                   accept;
    logic [RowW-1:0]        h_eff;
    logic [ColW-1:0]        w_eff;
    logic [RowW-1:0]        cur_r;
    logic [ColW-1:0]        cur_c;
    logic                   cur_eor;
    logic                   cur_final;

    logic                   shift;
    logic                   shift_clear;
    logic [2:0][SAMPLE_BITS-1:0] col_new;
    logic [2:0][SAMPLE_BITS-1:0] col_chain [4];
    logic                   wr_en;
    logic [SAMPLE_BITS-1:0] gated_top;
    logic [SAMPLE_BITS-1:0] gated_mid;
    logic [SAMPLE_BITS-1:0] flush_top;
    logic                   flush_rd;
    logic [ColW-1:0]        flush_addr;
    logic                   rd_en;
    logic [AddrW-1:0]       rd_addr;
    logic [SAMPLE_BITS-1:0] rd_above;
    logic [SAMPLE_BITS-1:0] rd_mid;
    logic                   res_valid;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_height_reg <= gslm_pkg::RST_FRAME_HEIGHT;
            frame_width_reg  <= gslm_pkg::RST_FRAME_WIDTH;
            target_row_reg   <= gslm_pkg::RST_TARGET_ROW;
            target_col_reg   <= gslm_pkg::RST_TARGET_COL;
        end
        else if (cfg_valid)
        begin
            unique case (gslm_pkg::cfg_reg_t'(cfg_index))
                gslm_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                gslm_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                gslm_pkg::REG_TARGET_ROW:   target_row_reg   <= cfg_data;
                gslm_pkg::REG_TARGET_COL:   target_col_reg   <= cfg_data;
                default:                    target_col_reg   <= target_col_reg;
            endcase
        end
    end

    assign h_eff = (frame_height_reg == '0) ? RowW'(1) :
                   (32'(frame_height_reg) > 32'(MAX_HEIGHT)) ? RowW'(MAX_HEIGHT) :
                   RowW'(frame_height_reg);
    assign w_eff = (frame_width_reg == '0) ? ColW'(1) :
                   (32'(frame_width_reg) > 32'(MAX_WIDTH)) ? ColW'(MAX_WIDTH) :
                   ColW'(frame_width_reg);

    assign cur_r     = (row_cnt_reg < h_eff) ? row_cnt_reg : RowW'(h_eff - RowW'(1));
    assign cur_c     = (col_cnt_reg < w_eff) ? col_cnt_reg : ColW'(w_eff - ColW'(1));
    assign cur_eor   = (cur_c == ColW'(w_eff - ColW'(1)));
    assign cur_final = cur_eor && (cur_r == RowW'(h_eff - RowW'(1)));

    assign advance  = !out_valid || out_ready;
    assign in_ready = advance && (state_reg == ST_RUN) && !(s1_valid_reg && s1_eor_reg);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        row_cnt_next = row_cnt_reg;
        col_cnt_next = col_cnt_reg;
        if (accept)
        begin
            if (cur_final)
            begin
                row_cnt_next = '0;
                col_cnt_next = '0;
            end
            else if (cur_eor)
            begin
                row_cnt_next = RowW'(cur_r + 1'b1);
                col_cnt_next = '0;
            end
            else
            begin
                row_cnt_next = cur_r;
                col_cnt_next = ColW'(cur_c + 1'b1);
            end
        end
    end

    assign gated_top = (s1_r_reg > RowW'(1)) ? rd_above : '0;
    assign gated_mid = (s1_r_reg != '0) ? rd_mid : '0;
    assign flush_top = (s1_r_reg != '0) ? rd_above : '0;

    always_comb
    begin
        state_next     = state_reg;
        fl_j_next      = fl_j_reg;
        s1_valid_next  = s1_valid_reg;
        shift          = 1'b0;
        shift_clear    = 1'b0;
        col_new        = '0;
        wr_en          = 1'b0;
        flush_rd       = 1'b0;
        flush_addr     = '0;
        tag_next       = '0;
        row1_next      = row1_reg;
        col1_next      = col1_reg;
        if (advance)
        begin
            unique case (state_reg)
                ST_RUN:
                begin
                    if (s1_valid_reg)
                    begin
                        s1_valid_next = 1'b0;
                        shift         = 1'b1;
                        shift_clear   = (s1_c_reg == '0);
                        col_new       = {s1_sample_reg, gated_mid, gated_top};
                        wr_en         = 1'b1;
                        tag_next.probe = (s1_r_reg != '0) && (s1_c_reg != '0);
                        tag_next.last  = !s1_final_reg;
                        row1_next      = s1_r_reg;
                        col1_next      = s1_c_reg;
                        if (s1_eor_reg)
                        begin
                            state_next = ST_EOR;
                        end
                    end
                end
                ST_EOR:
                begin
                    shift          = 1'b1;
                    tag_next.probe = (s1_r_reg != '0);
                    tag_next.last  = !s1_final_reg;
                    row1_next      = s1_r_reg;
                    col1_next      = ColW'(s1_c_reg + 1'b1);
                    if (s1_final_reg)
                    begin
                        flush_rd   = 1'b1;
                        flush_addr = '0;
                        fl_j_next  = '0;
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        state_next = ST_RUN;
                    end
                end
                ST_FLUSH:
                begin
                    shift          = 1'b1;
                    shift_clear    = (fl_j_reg == '0);
                    tag_next.probe = (fl_j_reg != '0);
                    row1_next      = RowW'(s1_r_reg + 1'b1);
                    col1_next      = fl_j_reg;
                    fl_j_next      = ColW'(fl_j_reg + 1'b1);
                    if (fl_j_reg < w_eff)
                    begin
                        col_new    = {{SAMPLE_BITS{1'b0}}, rd_mid, flush_top};
                        flush_rd   = 1'b1;
                        flush_addr = ColW'(fl_j_reg + 1'b1);
                    end
                    else
                    begin
                        state_next = ST_SUM;
                    end
                end
                ST_SUM:
                begin
                    tag_next.summary = 1'b1;
                    tag_next.last    = 1'b1;
                    state_next       = ST_RUN;
                end
                default:
                begin
                    state_next = ST_RUN;
                end
            endcase
        end
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
    end

    assign rd_en   = accept || flush_rd;
    assign rd_addr = accept ? cur_c[AddrW-1:0] : flush_addr[AddrW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cnt_reg  <= '0;
            col_cnt_reg  <= '0;
            s1_valid_reg <= 1'b0;
            s1_r_reg     <= '0;
            s1_c_reg     <= '0;
            s1_eor_reg   <= 1'b0;
            s1_final_reg <= 1'b0;
            state_reg    <= ST_RUN;
            fl_j_reg     <= '0;
            tag_reg      <= '0;
        end
        else
        begin
            row_cnt_reg  <= row_cnt_next;
            col_cnt_reg  <= col_cnt_next;
            s1_valid_reg <= s1_valid_next;
            state_reg    <= state_next;
            fl_j_reg     <= fl_j_next;
            if (advance)
            begin
                tag_reg <= tag_next;
            end
            if (accept)
            begin
                s1_r_reg     <= cur_r;
                s1_c_reg     <= cur_c;
                s1_eor_reg   <= cur_eor;
                s1_final_reg <= cur_final;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sample_reg <= sample;
        end
        row1_reg <= row1_next;
        col1_reg <= col1_next;
    end

    gslm_line_buf #(
        .MAX_WIDTH   (MAX_WIDTH),
        .SAMPLE_BITS (SAMPLE_BITS),
        .ADDR_W      (AddrW)
    ) u_line_buf (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (s1_c_reg[AddrW-1:0]),
        .wr_above (gated_mid),
        .wr_mid   (s1_sample_reg),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_above (rd_above),
        .rd_mid   (rd_mid)
    );

    assign col_chain[3] = col_new;

    for (genvar k = 0; k < 3; k++)
    begin : g_cell
        gslm_cell #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_cell (
            .clk     (clk),
            .shift   (shift),
            .clear   (shift_clear && (k < 2)),
            .col_in  (col_chain[k+1]),
            .col_out (col_chain[k])
        );
    end

    gslm_probe #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .ROW_W       (RowW),
        .COL_W       (ColW)
    ) u_probe (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .tag          (tag_reg),
        .row1         (row1_reg),
        .col1         (col1_reg),
        .win_left     (col_chain[0]),
        .win_centre   (col_chain[1]),
        .win_right    (col_chain[2]),
        .target_row   (target_row_reg),
        .target_col   (target_col_reg),
        .out_valid    (res_valid),
        .peak_row     (peak_row),
        .peak_col     (peak_col),
        .peak_ordinal (peak_ordinal),
        .is_summary   (is_summary),
        .target_hit   (target_hit),
        .last_of_run  (last_of_run)
    );

    assign out_valid = res_valid;

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import gslm_pkg::*;

    localparam int SB          = DEF_SAMPLE_BITS;
    localparam int MAXW        = DEF_MAX_WIDTH;
    localparam int MAXH        = DEF_MAX_HEIGHT;
    localparam int SETTLE      = 2 * MAXW + 20;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 4000;
    localparam int REPORT_CAP  = 40;
    localparam int RANDOM_ITEMS = 180;

    localparam logic signed [SB-1:0] S_MIN = {1'b1, {(SB-1){1'b0}}};
    localparam logic signed [SB-1:0] S_MAX = {1'b0, {(SB-1){1'b1}}};

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic [ORD_W-1:0] ordinal;
        logic             summary;
        logic             hit;
        logic             last;
    } peak_rec_t;

    class peak_checker;
        int frame_h;
        int frame_w;
        int tgt_row;
        int tgt_col;
        logic signed [SB-1:0] line_above [MAXW];
        logic signed [SB-1:0] line_mid [MAXW];
        logic signed [SB-1:0] win [3][3];
        int row_pos;
        int col_pos;
        int peak_total;
        bit target_seen;
        peak_rec_t pending_peaks[$];
        peak_rec_t batch[$];
        int errors;

        function new();
            frame_h = int'(RST_FRAME_HEIGHT);
            frame_w = int'(RST_FRAME_WIDTH);
            tgt_row = int'(RST_TARGET_ROW);
            tgt_col = int'(RST_TARGET_COL);
            foreach (line_above[i]) line_above[i] = '0;
            foreach (line_mid[i]) line_mid[i] = '0;
            clear_window();
            row_pos = 0;
            col_pos = 0;
            peak_total = 0;
            target_seen = 0;
            errors = 0;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [CFG_W-1:0] v);
            case (idx)
                REG_FRAME_HEIGHT: frame_h = int'(v);
                REG_FRAME_WIDTH:  frame_w = int'(v);
                REG_TARGET_ROW:   tgt_row = int'(v);
                REG_TARGET_COL:   tgt_col = int'(v);
                default: ;
            endcase
        endfunction

        function int eff_width();
            int w;
            w = frame_w;
            if (w < 1) w = 1;
            if (w > MAXW) w = MAXW;
            return w;
        endfunction

        function int eff_height();
            int h;
            h = frame_h;
            if (h < 1) h = 1;
            if (h > MAXH) h = MAXH;
            return h;
        endfunction

        function void clear_window();
            foreach (win[k, j]) win[k][j] = '0;
        endfunction

        function void shift_col(logic signed [SB-1:0] top, logic signed [SB-1:0] mid,
                                logic signed [SB-1:0] bot);
            for (int k = 0; k < 3; k++)
            begin
                win[k][0] = win[k][1];
                win[k][1] = win[k][2];
            end
            win[0][2] = top;
            win[1][2] = mid;
            win[2][2] = bot;
        endfunction

        function bit centre_peak();
            for (int k = 0; k < 3; k++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    if (!(k == 1 && j == 1) && win[1][1] <= win[k][j])
                        return 1'b0;
                end
            end
            return 1'b1;
        endfunction

        function void push_result(int r, int c, int ord, bit summ, bit hit);
            peak_rec_t rec;
            rec.row = POS_W'(r);
            rec.col = POS_W'(c);
            rec.ordinal = ORD_W'(ord);
            rec.summary = summ;
            rec.hit = hit;
            rec.last = 1'b0;
            batch.push_back(rec);
        endfunction

        function void judge(int r0, int c0);
            if (!centre_peak())
                return;
            if (peak_total < 2047)
                peak_total++;
            if (r0 + 1 == tgt_row && c0 + 1 == tgt_col)
                target_seen = 1'b1;
            push_result(r0 + 1, c0 + 1, peak_total, 1'b0, 1'b0);
        endfunction

        function void take_sample(logic signed [SB-1:0] x);
            int w;
            int h;
            int r;
            int c;
            logic signed [SB-1:0] top;
            logic signed [SB-1:0] mid;
            peak_rec_t rec;
            batch.delete();
            w = eff_width();
            h = eff_height();
            r = (row_pos < h) ? row_pos : h - 1;
            c = (col_pos < w) ? col_pos : w - 1;
            if (c == 0)
                clear_window();
            top = (r >= 2) ? line_above[c] : '0;
            mid = (r >= 1) ? line_mid[c] : '0;
            line_above[c] = mid;
            line_mid[c] = x;
            shift_col(top, mid, x);
            if (r >= 1 && c >= 1)
                judge(r - 1, c - 1);
            if (c == w - 1)
            begin
                if (r >= 1)
                begin
                    shift_col('0, '0, '0);
                    judge(r - 1, c);
                end
                if (r == h - 1)
                begin
                    // The final row is replayed through the window with a zero row below it.
                    clear_window();
                    for (int j = 0; j <= w; j++)
                    begin
                        if (j < w)
                            shift_col((r >= 1) ? line_above[j] : '0, line_mid[j], '0);
                        else
                            shift_col('0, '0, '0);
                        if (j >= 1)
                            judge(r, j - 1);
                    end
                    push_result(0, 0, peak_total, 1'b1, target_seen);
                    row_pos = 0;
                    col_pos = 0;
                    peak_total = 0;
                    target_seen = 1'b0;
                end
                else
                begin
                    row_pos = r + 1;
                    col_pos = 0;
                end
            end
            else
            begin
                row_pos = r;
                col_pos = c + 1;
            end
            foreach (batch[i])
            begin
                rec = batch[i];
                rec.last = (i == batch.size() - 1);
                pending_peaks.push_back(rec);
            end
        endfunction

        task report(string msg);
            errors++;
            if (errors <= REPORT_CAP)
                $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        task check_peak(peak_rec_t got);
            peak_rec_t want;
            if (pending_peaks.size() == 0)
            begin
                report($sformatf("unexpected transaction row %0d col %0d ordinal %0d",
                                 got.row, got.col, got.ordinal));
                return;
            end
            want = pending_peaks.pop_front();
            if (got.row !== want.row)
                report($sformatf("peak_row got %0d want %0d", got.row, want.row));
            if (got.col !== want.col)
                report($sformatf("peak_col got %0d want %0d", got.col, want.col));
            if (got.ordinal !== want.ordinal)
                report($sformatf("peak_ordinal got %0d want %0d", got.ordinal, want.ordinal));
            if (got.summary !== want.summary)
                report($sformatf("is_summary got %b want %b", got.summary, want.summary));
            if (got.hit !== want.hit)
                report($sformatf("target_hit got %b want %b", got.hit, want.hit));
            if (got.last !== want.last)
                report($sformatf("last_of_run got %b want %b", got.last, want.last));
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic signed [SB-1:0]  sample;
    logic                  out_valid;
    logic                  out_ready;
    logic [POS_W-1:0]      peak_row;
    logic [POS_W-1:0]      peak_col;
    logic [ORD_W-1:0]      peak_ordinal;
    logic                  is_summary;
    logic                  target_hit;
    logic                  last_of_run;
    logic                  cfg_valid;
    logic                  cfg_ready;
    cfg_reg_t              cfg_index;
    logic [CFG_W-1:0]      cfg_data;

    peak_checker chk;
    logic signed [SB-1:0] script[$];
    int snd_idle;
    int rcv_stall;
    int hold_requests;

    grid_strict_local_maxima dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample       (sample),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .peak_row     (peak_row),
        .peak_col     (peak_col),
        .peak_ordinal (peak_ordinal),
        .is_summary   (is_summary),
        .target_hit   (target_hit),
        .last_of_run  (last_of_run),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        peak_rec_t got;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                chk.write_reg(cfg_index, cfg_data);
            if (in_valid && in_ready)
                chk.take_sample(sample);
            if (out_valid && out_ready)
            begin
                got = {peak_row, peak_col, peak_ordinal, is_summary, target_hit, last_of_run};
                chk.check_peak(got);
            end
        end
    end

    initial
    begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_requests != hold_seen)
            begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_ready = 1'b0;
                hold_left--;
            end
            else
                out_ready = ($urandom_range(99) >= rcv_stall);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TEST FAILED");
        $finish;
    end

    task write_reg(cfg_reg_t idx, int value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = CFG_W'(value);
        do @(posedge clk); while (!cfg_ready);
    endtask

    task send_sample(logic signed [SB-1:0] x);
        @(negedge clk);
        while ($urandom_range(99) < snd_idle)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        sample = x;
        do @(posedge clk); while (!in_ready);
    endtask

    function logic signed [SB-1:0] random_sample();
        int v;
        case ($urandom_range(9))
            0, 1, 2, 3:
            begin
                v = $urandom_range(6);
                return SB'(v - 3);
            end
            4, 5, 6: return SB'($urandom());
            7: return S_MAX;
            8: return S_MIN;
            default: return SB'($urandom_range(1000));
        endcase
    endfunction

    task drain();
        while (chk.pending_peaks.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Registers are written with the block idle; samples come from the script if it holds any.
    task run_phase(int h, int w, int tr, int tc, int n, int mode, bit hold);
        write_reg(REG_FRAME_HEIGHT, h);
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_TARGET_ROW, tr);
        write_reg(REG_TARGET_COL, tc);
        @(negedge clk);
        cfg_valid = 1'b0;
        case (mode)
            1: begin snd_idle = 80; rcv_stall = 0;  end
            2: begin snd_idle = 0;  rcv_stall = 80; end
            3: begin snd_idle = 23; rcv_stall = 23; end
            default: begin snd_idle = 0; rcv_stall = 0; end
        endcase
        if (hold)
            hold_requests++;
        for (int i = 0; i < n; i++)
        begin
            if (script.size() != 0)
                send_sample(script.pop_front());
            else
                send_sample(random_sample());
        end
        @(negedge clk);
        in_valid = 1'b0;
        drain();
    endtask

    initial
    begin
        int done_items;
        int phase_no;
        int h;
        int w;
        int n;
        int weff;
        int heff;
        bit mid_frame;
        chk = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        sample = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_FRAME_HEIGHT;
        cfg_data = '0;
        snd_idle = 0;
        rcv_stall = 0;
        hold_requests = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // A lone maximum at the target, surrounded by the most negative value.
        script = '{S_MIN, S_MIN, S_MIN, S_MIN, S_MAX, S_MIN, S_MIN, S_MIN, S_MIN};
        run_phase(3, 3, 2, 2, script.size(), 0, 1'b0);
        // Zero sizes act as a one-sample frame; a zero sample ties with the zero border.
        script = '{16'sd1, -16'sd1, 16'sd0};
        run_phase(0, 0, 1, 1, script.size(), 0, 1'b0);
        script = '{S_MAX, S_MAX, -16'sd1, 16'sd2, S_MIN, 16'sd0, -16'sd5, 16'sd1};
        run_phase(2, 4, 65, 0, script.size(), 0, 1'b0);

        done_items = 0;
        // Oversized width clamps to a full 64-sample row.
        run_phase(0, 127, 1, $urandom_range(1, 64), 64, 2, 1'b0);
        // Long receiver hold-off while the sender keeps offering samples.
        run_phase(3, 6, $urandom_range(1, 3), $urandom_range(1, 6), 36, 0, 1'b1);
        // Height shrunk in mid-frame: the next sample becomes the last row.
        run_phase(64, 1, 2, 1, 20, 3, 1'b0);
        run_phase(2, 1, 1, 1, 5, 0, 1'b0);
        // Width shrunk in mid-row: the next sample becomes the last column.
        run_phase(3, 8, 2, 3, 13, 1, 1'b0);
        run_phase(3, 3, 3, 3, 13, 2, 1'b0);
        done_items = 64 + 36 + 20 + 5 + 13 + 13;

        phase_no = 0;
        while (done_items < RANDOM_ITEMS)
        begin
            mid_frame = (chk.row_pos != 0) || (chk.col_pos != 0);
            w = ($urandom_range(5) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 6);
            if (mid_frame && w > chk.eff_width())
                w = $urandom_range(1, chk.eff_width());
            if ($urandom_range(9) == 0)
                w = 0;
            h = $urandom_range(0, 4);
            weff = (w == 0) ? 1 : w;
            heff = (h == 0) ? 1 : h;
            n = heff * weff * $urandom_range(1, 2);
            if ($urandom_range(3) == 0)
                n += $urandom_range(1, 5);
            run_phase(h, w, $urandom_range(0, heff + 1), $urandom_range(0, weff + 1), n,
                      phase_no % 4, 1'b0);
            done_items += n;
            phase_no++;
        end

        if (chk.errors == 0 && chk.pending_peaks.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
